// File: src/assert_macros.svh
// assertion helpers for the divider parameter checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/frd_pkg.sv
package frd_pkg;
  localparam int unsigned FreqW = 28;
  localparam int unsigned VcoW  = 30;
  localparam int unsigned BW    = 20;
  localparam int unsigned NumW  = 48;
  localparam int unsigned P1W   = 18;
  localparam int unsigned P2W   = 20;
  localparam int unsigned P3W   = 20;

  localparam logic [P3W-1:0]  FracDen  = 20'd1048575;
  localparam logic [VcoW-1:0] VcoReset = 30'd675000000;
  localparam logic [37:0]     P1Max    = 38'd262143;
  localparam logic [37:0]     P1Offset = 38'd512;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [VcoW-1:0]  quo;
    logic [FreqW-1:0] rem;
  } idiv_t;

  typedef struct packed {
    logic [VcoW-1:0] quo;
    logic [BW-1:0]   frac;
    logic            err;
  } fdiv_t;
endpackage

// File: src/frd_int_div.sv
module frd_int_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [frd_pkg::FreqW-1:0] freq_i,
  input  logic [frd_pkg::VcoW-1:0]  vco_i,
  output logic                    valid_o,
  output frd_pkg::idiv_t          res_o
);
  import frd_pkg::*;

  logic             vld  [VcoW+1];
  logic [FreqW-1:0] frq  [VcoW+1];
  logic [VcoW-1:0]  num  [VcoW+1];
  logic [VcoW-1:0]  quo  [VcoW+1];
  logic [FreqW-1:0] rem  [VcoW+1];

  assign vld[0] = valid_i;
  assign frq[0] = freq_i;
  assign num[0] = vco_i;
  assign quo[0] = '0;
  assign rem[0] = '0;

  for (genvar s = 0; s < VcoW; s++) begin : g_stage
    logic [FreqW:0] trial;
    logic           ge;
    assign trial = {rem[s], num[s][VcoW-1]};
    assign ge    = trial >= {1'b0, frq[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        frq[s+1] <= frq[s];
        num[s+1] <= {num[s][VcoW-2:0], 1'b0};
        quo[s+1] <= {quo[s][VcoW-2:0], ge};
        rem[s+1] <= ge ? FreqW'(trial - {1'b0, frq[s]}) : trial[FreqW-1:0];
      end
    end
  end

  assign valid_o    = vld[VcoW];
  assign res_o.freq = frq[VcoW];
  assign res_o.quo  = quo[VcoW];
  assign res_o.rem  = rem[VcoW];
endmodule

// File: src/frd_frac_div.sv
module frd_frac_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  frd_pkg::idiv_t div_i,
  output logic           valid_o,
  output frd_pkg::fdiv_t res_o
);
  import frd_pkg::*;

  logic             vld [BW+1];
  logic [FreqW-1:0] frq [BW+1];
  logic [NumW-1:0]  rmd [BW+1];
  logic [BW-1:0]    frc [BW+1];
  logic [VcoW-1:0]  quo [BW+1];
  logic             err [BW+1];

  // numerator rem * (2^20 - 1) + freq / 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en_i) begin
      vld[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frq[0] <= div_i.freq;
      rmd[0] <= {div_i.rem, {BW{1'b0}}} - NumW'(div_i.rem) + NumW'(div_i.freq >> 1);
      frc[0] <= '0;
      quo[0] <= div_i.quo;
      err[0] <= (div_i.freq == '0) || (div_i.quo < VcoW'(4));
    end
  end

  for (genvar s = 0; s < BW; s++) begin : g_stage
    logic [NumW-1:0] dsh;
    logic            ge;
    assign dsh = NumW'(frq[s]) << (BW - 1 - s);
    assign ge  = rmd[s] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        frq[s+1] <= frq[s];
        rmd[s+1] <= ge ? rmd[s] - dsh : rmd[s];
        frc[s+1] <= {frc[s][BW-2:0], ge};
        quo[s+1] <= quo[s];
        err[s+1] <= err[s];
      end
    end
  end

  assign valid_o    = vld[BW];
  assign res_o.quo  = quo[BW];
  assign res_o.frac = frc[BW];
  assign res_o.err  = err[BW];
endmodule

// File: src/frd_post.sv
module frd_post (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  frd_pkg::fdiv_t          div_i,
  output logic                    valid_o,
  output logic [frd_pkg::P1W-1:0] p1_o,
  output logic [frd_pkg::P2W-1:0] p2_o,
  output logic [frd_pkg::P3W-1:0] p3_o,
  output logic                    err_o
);
  import frd_pkg::*;

  logic [26:0]     x;
  logic [6:0]      q0;
  logic [20:0]     r0;
  logic            ge;
  logic            a_vld_q;
  logic [7:0]      a_q_q;
  logic [P2W-1:0]  a_p2_q;
  logic [VcoW-1:0] a_quo_q;
  logic            a_err_q;
  logic [37:0]     p1_full;
  logic            bad;

  // 128*b divided by 2^20 - 1
  assign x  = {div_i.frac, 7'b0};
  assign q0 = x[26:20];
  assign r0 = {1'b0, x[19:0]} + 21'(q0);
  assign ge = r0 >= {1'b0, FracDen};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      valid_o <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q_q   <= {1'b0, q0} + {7'b0, ge};
      a_p2_q  <= ge ? P2W'(r0 - {1'b0, FracDen}) : r0[P2W-1:0];
      a_quo_q <= div_i.quo;
      a_err_q <= div_i.err;
    end
  end

  assign p1_full = {1'b0, a_quo_q, 7'b0} + 38'(a_q_q) - P1Offset;
  assign bad     = a_err_q || (p1_full > P1Max);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_o  <= bad ? '0 : p1_full[P1W-1:0];
      p2_o  <= bad ? '0 : a_p2_q;
      p3_o  <= bad ? '0 : FracDen;
      err_o <= bad;
    end
  end
endmodule

// File: src/fractional_divider_params.sv
// Fractional clock-divider parameter engine: each item on the slave stream
// carries a wanted output frequency in Hz and yields one result with P1, P2,
// P3 and a range flag for the VCO frequency held in the configuration
// register (reset 675000000 Hz). One item is accepted per cycle. The
// pipeline is built from two restoring dividers that retire one quotient bit
// per stage (30 stages for the integer part, 20 for the fraction numerator),
// plus one numerator stage and two output stages. The whole pipeline holds
// while a result waits on m_axis_tready.
module fractional_divider_params (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,     // [29:0] vco_frequency
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [27:0] output_frequency
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [17:0] p1_word, [37:18] p2_word, [57:38] p3_word
  output logic        m_axis_tuser    // [0] range_error
);
  import frd_pkg::*;

  logic [VcoW-1:0] vco_q;
  logic            en;
  logic            idiv_vld;
  idiv_t           idiv_res;
  logic            fdiv_vld;
  fdiv_t           fdiv_res;
  logic [P1W-1:0]  p1;
  logic [P2W-1:0]  p2;
  logic [P3W-1:0]  p3;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vco_q <= VcoReset;
    end else if (cfg_valid_i) begin
      vco_q <= cfg_data_i[VcoW-1:0];
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  frd_int_div u_int_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .freq_i  (s_axis_tdata[FreqW-1:0]),
    .vco_i   (vco_q),
    .valid_o (idiv_vld),
    .res_o   (idiv_res)
  );

  frd_frac_div u_frac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (idiv_vld),
    .div_i   (idiv_res),
    .valid_o (fdiv_vld),
    .res_o   (fdiv_res)
  );

  frd_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fdiv_vld),
    .div_i   (fdiv_res),
    .valid_o (m_axis_tvalid),
    .p1_o    (p1),
    .p2_o    (p2),
    .p3_o    (p3),
    .err_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, p3, p2, p1};
endmodule

// File: src/frd_checker.sv
`include "assert_macros.svh"

module frd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // stalled result holds
  `FRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // error clears all words
  `FRD_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata == 64'd0)
  // good result carries the fixed denominator
  `FRD_ASSERT_IMPL(a_p3_den, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata[57:38] == 20'd1048575 && m_axis_tdata[37:18] != 20'd1048575)
  // input only stalls behind a waiting result
  `FRD_ASSERT_IMPL(a_ready, clk_i, rst_ni, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready)
endmodule

bind fractional_divider_params frd_checker u_frd_checker (.*);

// File: verif/tb_top.sv
module tb_top;
  import frd_pkg::*;

  typedef struct packed {
    logic [19:0] p3;
    logic [19:0] p2;
    logic [17:0] p1;
    logic        err;
  } divword_t;

  typedef struct {
    logic [27:0] freq;
    logic        known;
    divword_t    words;
  } freq_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [29:0] vco_hz;
  divword_t    expected_words[$];
  int          n_errors;
  int          n_results;
  int          n_sent;
  bit          idle_enable;

  fractional_divider_params dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  function automatic divword_t divider_words(logic [29:0] vco, logic [27:0] f);
    logic [63:0] a, r, b, q, p1, den;
    divword_t    w;
    w = '0;
    den = 64'd1048575;
    if (f == 0) begin
      w.err = 1'b1;
      return w;
    end
    a = vco / f;
    r = vco - a * f;
    if (a < 4) begin
      w.err = 1'b1;
      return w;
    end
    b = (den * r + f / 2) / f;
    q = (128 * b) / den;
    p1 = 128 * a + q - 512;
    if (p1 > 64'd262143) begin
      w.err = 1'b1;
      return w;
    end
    w.p1 = p1[17:0];
    w.p2 = 20'((128 * b) - den * q);
    w.p3 = den[19:0];
    return w;
  endfunction

  task automatic write_vco(logic [29:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= {2'b00, value};
    do @(posedge clk_i); while (!cfg_ready_o);
    vco_hz = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_freq(logic [27:0] f, bit known, divword_t words);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    expected_words.push_back(known ? words : divider_words(vco_hz, f));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, f};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_words.size() != 0) begin
      $display("%0t pending results exp 0 got %0d", $time, expected_words.size());
      n_errors++;
      expected_words.delete();
    end
    repeat (80) @(negedge clk_i);
  endtask

  function automatic logic [27:0] pick_freq();
    case ($urandom_range(0, 5))
      0: return 28'($urandom_range(0, 32'h0FFFFFFF));
      1: return 28'($urandom_range(1, 1000));
      2: return 28'($urandom_range(2000, 200000000));
      3: return 28'(vco_hz / $urandom_range(4, 2100));
      4: return 28'($urandom_range(0, 15));
      default: return 28'($urandom_range(1000000, 200000000));
    endcase
  endfunction

  // stall bursts on the result side
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    divword_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.p1  = m_axis_tdata[17:0];
      got.p2  = m_axis_tdata[37:18];
      got.p3  = m_axis_tdata[57:38];
      got.err = m_axis_tuser;
      n_results++;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected result p1=%0d p2=%0d p3=%0d err=%0b",
                 $time, got.p1, got.p2, got.p3, got.err);
        n_errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.p1 !== exp_w.p1) begin
          $display("%0t p1 exp %0d got %0d", $time, exp_w.p1, got.p1);
          n_errors++;
        end
        if (got.p2 !== exp_w.p2) begin
          $display("%0t p2 exp %0d got %0d", $time, exp_w.p2, got.p2);
          n_errors++;
        end
        if (got.p3 !== exp_w.p3) begin
          $display("%0t p3 exp %0d got %0d", $time, exp_w.p3, got.p3);
          n_errors++;
        end
        if (got.err !== exp_w.err) begin
          $display("%0t range_error exp %0b got %0b", $time, exp_w.err, got.err);
          n_errors++;
        end
      end
    end
  end

  initial begin
    freq_row_t   rows[$];
    divword_t    bad;
    logic [29:0] vco_set[6];
    int          k;
    bad = '0;
    bad.err = 1'b1;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    vco_hz = 30'd675000000;
    n_errors = 0;
    n_results = 0;
    n_sent = 0;
    idle_enable = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows at the reset vco
    rows = '{
      '{28'd0, 1'b1, bad},
      '{28'h0FFFFFF, 1'b0, bad},
      '{28'hFFFFFFF, 1'b1, bad},
      '{28'd225000000, 1'b1, bad},
      '{28'd168750000, 1'b0, bad},
      '{28'd168750001, 1'b1, bad},
      '{28'd1, 1'b1, bad},
      '{28'd2575, 1'b1, bad},
      '{28'd2576, 1'b0, bad},
      '{28'd10000000, 1'b0, bad},
      '{28'd100000000, 1'b0, bad},
      '{28'd200000000, 1'b1, bad},
      '{28'd7, 1'b0, bad},
      '{28'd33333333, 1'b0, bad},
      '{28'd123456789, 1'b0, bad},
      '{28'h5555555, 1'b0, bad},
      '{28'h2AAAAAA, 1'b0, bad}
    };
    foreach (rows[i]) send_freq(rows[i].freq, rows[i].known, rows[i].words);
    drain();

    // directed rows at extreme vco settings
    write_vco(30'd0);
    send_freq(28'd1, 1'b1, bad);
    send_freq(28'd0, 1'b1, bad);
    drain();
    write_vco(30'h3FFFFFFF);
    send_freq(28'hFFFFFFF, 1'b0, bad);
    send_freq(28'd4096, 1'b0, bad);
    send_freq(28'd3999999, 1'b0, bad);
    drain();

    vco_set = '{30'd675000000, 30'd1, 30'd1000000000, 30'h3FFFFFFF,
                30'h2AAAAAAA, 30'd900000000};
    idle_enable = 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      write_vco(ph < 6 ? vco_set[ph] : 30'($urandom_range(600000000, 900000000)));
      if (ph == 6) idle_enable = 1'b0;
      for (k = 0; k < 100; k++) send_freq(pick_freq(), 1'b0, bad);
      drain();
    end

    $display("covered %0d items over several vco settings incl. extremes, %0d results",
             n_sent, n_results);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
